@@ rtl/ntc_pkg.sv @@
package ntc_pkg;

   localparam int SAMPLE_COUNT  = 4;
   localparam int TABLE_ENTRIES = 18;

   localparam int ADC_W     = 12;
   localparam int SUM_W     = ADC_W + $clog2(SAMPLE_COUNT);
   localparam int CNT_W     = $clog2(SAMPLE_COUNT + 1);
   localparam int SEG_W     = $clog2(TABLE_ENTRIES - 1);
   localparam int LAST_SEG  = TABLE_ENTRIES - 2;
   localparam int RANGE_W   = 8;
   localparam int FRAC_W    = 7;
   localparam int PCT_SCALE = 100;
   localparam int NUM_W     = RANGE_W + FRAC_W;
   localparam int DIV_W     = (SUM_W > NUM_W) ? SUM_W : NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int TEMP_W    = 11;
   localparam int CFG_W     = 12;
   localparam int FAULT_W   = 3;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   localparam int SEG_STEP_TENTHS = 50;

   localparam logic signed [CFG_W-1:0]  THRESHOLD_RESET = 12'sd500;
   localparam logic [ADC_W-1:0]         OPEN_RESET      = 12'd10;
   localparam logic [ADC_W-1:0]         SHORT_RESET     = 12'd4085;
   localparam logic signed [TEMP_W-1:0] HELD_RESET      = 11'sd250;

   localparam logic [FAULT_W-1:0] FAULT_OK        = 3'd0;
   localparam logic [FAULT_W-1:0] FAULT_OPEN      = 3'd1;
   localparam logic [FAULT_W-1:0] FAULT_SHORT     = 3'd2;
   localparam logic [FAULT_W-1:0] FAULT_HOT       = 3'd3;
   localparam logic [FAULT_W-1:0] FAULT_COLD      = 3'd4;
   localparam logic [FAULT_W-1:0] FAULT_NONE_GOOD = 3'd5;

   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_OPEN      = 2'd1;
   localparam logic [1:0] REG_SHORT     = 2'd2;

   // ADC counts at -5 C to 80 C in 5 C steps, descending
   localparam logic [ADC_W-1:0] LUT_COUNTS [TABLE_ENTRIES] = '{
      12'd3338, 12'd3155, 12'd2959, 12'd2738, 12'd2509, 12'd2275,
      12'd2048, 12'd1828, 12'd1614, 12'd1413, 12'd1238, 12'd1082,
      12'd937,  12'd816,  12'd708,  12'd613,  12'd531,  12'd461
   };

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [CNT_W-1:0] count;
   } acc_type;

   typedef struct packed {
      logic             cold;
      logic             hot;
      logic [SEG_W-1:0] seg;
   } seg_info_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [RANGE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/ntc_if.sv @@
interface ntc_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] sample_a;
   logic [11:0] sample_b;
   logic [11:0] sample_c;
   logic [11:0] sample_d;
   logic        lost_a;
   logic        lost_b;
   logic        lost_c;
   logic        lost_d;

   modport source (
      output valid, sample_a, sample_b, sample_c, sample_d,
             lost_a, lost_b, lost_c, lost_d,
      input  ready
   );
   modport sink (
      input  valid, sample_a, sample_b, sample_c, sample_d,
             lost_a, lost_b, lost_c, lost_d,
      output ready
   );
endinterface

interface ntc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [10:0] temp_tenths;
   logic               reading_valid;
   logic [2:0]         fault_code;
   logic               above_flag;
   logic [2:0]         good_count;

   modport source (
      output valid, temp_tenths, reading_valid, fault_code, above_flag, good_count,
      input  ready
   );
   modport sink (
      input  valid, temp_tenths, reading_valid, fault_code, above_flag, good_count,
      output ready
   );
endinterface

@@ rtl/ntc_accum.sv @@
module ntc_accum
   import ntc_pkg::*;
(
   input  logic [ADC_W-1:0]        samples [SAMPLE_COUNT],
   input  logic [SAMPLE_COUNT-1:0] lost,
   output acc_type                 acc
);

   logic [SUM_W-1:0] lane_val [SAMPLE_COUNT];
   logic [SAMPLE_COUNT-1:0] lane_good;

   // one lane per sample: drop timed-out conversions
   for (genvar i = 0; i < SAMPLE_COUNT; i++) begin : g_lane
      assign lane_good[i] = ~lost[i];
      assign lane_val[i]  = lost[i] ? '0 : SUM_W'(samples[i]);
   end

   always_comb begin
      acc.sum   = '0;
      acc.count = '0;
      for (int i = 0; i < SAMPLE_COUNT; i++) begin
         acc.sum   = acc.sum + lane_val[i];
         acc.count = acc.count + CNT_W'(lane_good[i]);
      end
   end

endmodule

@@ rtl/ntc_seg_search.sv @@
module ntc_seg_search
   import ntc_pkg::*;
(
   input  logic [ADC_W-1:0] avg,
   output seg_info_type     seg_info
);

   logic [LAST_SEG-1:0] ge;

   // one compare lane per segment lower edge
   for (genvar k = 0; k < LAST_SEG; k++) begin : g_cmp
      assign ge[k] = (avg >= LUT_COUNTS[k + 1]);
   end

   always_comb begin
      seg_info.cold = (avg >= LUT_COUNTS[0]);
      seg_info.hot  = (avg <= LUT_COUNTS[TABLE_ENTRIES - 1]);
      seg_info.seg  = SEG_W'(LAST_SEG);
      // first segment whose lower edge the average reaches
      for (int k = LAST_SEG - 1; k >= 0; k--) begin
         if (ge[k]) begin
            seg_info.seg = SEG_W'(k);
         end
      end
   end

endmodule

@@ rtl/ntc_divider.sv @@
module ntc_divider
   import ntc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [RANGE_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [RANGE_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [RANGE_W:0] shifted;
   logic [RANGE_W:0] diff;
   logic             take;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign take    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         rem_in = take ? diff[RANGE_W-1:0] : shifted[RANGE_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ rtl/ntc_lut_temperature.sv @@
// channel   | port      | dir | word
// ----------+-----------+-----+------------------------------------------------
// request   | req_chan  | in  | sample_a..sample_d (12b), lost_a..lost_d (1b)
// response  | rsp_chan  | out | temp_tenths, reading_valid, fault_code,
//           |           |     | above_flag, good_count
// config    | psel ...  | in  | APB, regs threshold / open / short at 0, 4, 8
//
// One word at a time. A fresh temperature takes two passes through the shared
// bit-serial divider (average, then segment fraction): the result is registered
// in the response register, and the next request is taken once the block is
// back in idle. Table-end clamps skip the second pass, limit faults stop after
// the average, and a word with no good sample skips the divider entirely.
// Reset is synchronous, active high, and restores the registers and held value.
// A finished word waits in the response register; a word behind it holds in the
// last step until that register frees. req_chan.ready is high only when idle.
module ntc_lut_temperature
   import ntc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   ntc_req_if.sink           req_chan,
   ntc_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_AVG   = 3'd1;
   localparam logic [2:0] S_RANGE = 3'd2;
   localparam logic [2:0] S_NUM   = 3'd3;
   localparam logic [2:0] S_FRAC  = 3'd4;
   localparam logic [2:0] S_TEMP  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0]               state_ff, state_in;
   logic [CNT_W-1:0]         good_ff, good_in;
   logic [ADC_W-1:0]         avg_ff, avg_in;
   logic [SEG_W-1:0]         seg_ff, seg_in;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic [FAULT_W-1:0]       fault_ff, fault_in;
   logic                     fresh_ff, fresh_in;
   logic signed [TEMP_W-1:0] held_ff, held_in;

   logic signed [CFG_W-1:0]  thr_ff, thr_in;
   logic [ADC_W-1:0]         open_ff, open_in;
   logic [ADC_W-1:0]         short_ff, short_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] out_temp_ff, out_temp_in;
   logic                     out_fresh_ff, out_fresh_in;
   logic [FAULT_W-1:0]       out_fault_ff, out_fault_in;
   logic                     out_above_ff, out_above_in;
   logic [2:0]               out_good_ff, out_good_in;

   logic [ADC_W-1:0]        samples [SAMPLE_COUNT];
   logic [SAMPLE_COUNT-1:0] lost;
   acc_type                 acc;
   seg_info_type            seg_info;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   logic [ADC_W-1:0]   seg_lo;
   logic [ADC_W-1:0]   seg_hi;
   logic [RANGE_W-1:0] seg_range;
   logic [RANGE_W-1:0] num_diff;
   logic [DIV_W-1:0]   num;
   logic [TEMP_W-1:0]  seg_base;
   logic [TEMP_W-1:0]  temp_calc;
   logic               cfg_write;

   assign samples[0] = req_chan.sample_a;
   assign samples[1] = req_chan.sample_b;
   assign samples[2] = req_chan.sample_c;
   assign samples[3] = req_chan.sample_d;
   assign lost = {req_chan.lost_d, req_chan.lost_c, req_chan.lost_b, req_chan.lost_a};

   ntc_accum u_accum (
      .samples (samples),
      .lost    (lost),
      .acc     (acc)
   );

   ntc_seg_search u_seg_search (
      .avg      (avg_ff),
      .seg_info (seg_info)
   );

   ntc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign seg_lo    = LUT_COUNTS[seg_ff];
   assign seg_hi    = LUT_COUNTS[seg_ff + 1'b1];
   assign seg_range = RANGE_W'(seg_lo - seg_hi);
   assign num_diff  = RANGE_W'(seg_lo - avg_ff);
   assign num       = DIV_W'(num_diff) * DIV_W'(PCT_SCALE);
   assign seg_base  = TEMP_W'(seg_ff) * TEMP_W'(SEG_STEP_TENTHS);
   // -50 + 50*seg + frac/2
   assign temp_calc = seg_base + TEMP_W'(frac_ff[FRAC_W-1:1]) - TEMP_W'(SEG_STEP_TENTHS);

   assign req_chan.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      good_in  = good_ff;
      avg_in   = avg_ff;
      seg_in   = seg_ff;
      frac_in  = frac_ff;
      fault_in = fault_ff;
      fresh_in = fresh_ff;
      held_in  = held_ff;
      div_req  = '0;

      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      out_temp_in  = out_temp_ff;
      out_fresh_in = out_fresh_ff;
      out_fault_in = out_fault_ff;
      out_above_in = out_above_ff;
      out_good_in  = out_good_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               good_in = acc.count;
               if (acc.count == '0) begin
                  fault_in = FAULT_NONE_GOOD;
                  fresh_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_W'(acc.sum);
                  div_req.divisor  = RANGE_W'(acc.count);
                  state_in         = S_AVG;
               end
            end
         end
         S_AVG: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[ADC_W-1:0];
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            if (avg_ff < open_ff) begin
               fault_in = FAULT_OPEN;
               fresh_in = 1'b0;
               state_in = S_DONE;
            end else if (avg_ff > short_ff) begin
               fault_in = FAULT_SHORT;
               fresh_in = 1'b0;
               state_in = S_DONE;
            end else if (seg_info.cold) begin
               // pin to the first segment start
               fault_in = FAULT_COLD;
               seg_in   = '0;
               frac_in  = '0;
               state_in = S_TEMP;
            end else if (seg_info.hot) begin
               // pin to the last segment end
               fault_in = FAULT_HOT;
               seg_in   = SEG_W'(LAST_SEG);
               frac_in  = FRAC_W'(PCT_SCALE);
               state_in = S_TEMP;
            end else begin
               fault_in = FAULT_OK;
               seg_in   = seg_info.seg;
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            div_req.start    = 1'b1;
            div_req.dividend = num;
            div_req.divisor  = seg_range;
            state_in         = S_FRAC;
         end
         S_FRAC: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.quotient[FRAC_W-1:0];
               state_in = S_TEMP;
            end
         end
         S_TEMP: begin
            held_in  = $signed(temp_calc);
            fresh_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               out_temp_in  = held_ff;
               out_fresh_in = fresh_ff;
               out_fault_in = fault_ff;
               out_above_in = ($signed({held_ff[TEMP_W-1], held_ff}) > thr_ff);
               out_good_in  = 3'(good_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      thr_in   = thr_ff;
      open_in  = open_ff;
      short_in = short_ff;
      if (cfg_write) begin
         unique case (paddr[3:2])
            REG_THRESHOLD: thr_in   = $signed(pwdata[CFG_W-1:0]);
            REG_OPEN:      open_in  = pwdata[ADC_W-1:0];
            REG_SHORT:     short_in = pwdata[ADC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_THRESHOLD: prdata = DATA_W'(thr_ff);
         REG_OPEN:      prdata = DATA_W'(open_ff);
         REG_SHORT:     prdata = DATA_W'(short_ff);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= HELD_RESET;
         thr_ff       <= THRESHOLD_RESET;
         open_ff      <= OPEN_RESET;
         short_ff     <= SHORT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         thr_ff       <= thr_in;
         open_ff      <= open_in;
         short_ff     <= short_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      good_ff      <= good_in;
      avg_ff       <= avg_in;
      seg_ff       <= seg_in;
      frac_ff      <= frac_in;
      fault_ff     <= fault_in;
      fresh_ff     <= fresh_in;
      out_temp_ff  <= out_temp_in;
      out_fresh_ff <= out_fresh_in;
      out_fault_ff <= out_fault_in;
      out_above_ff <= out_above_in;
      out_good_ff  <= out_good_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.temp_tenths   = out_temp_ff;
   assign rsp_chan.reading_valid = out_fresh_ff;
   assign rsp_chan.fault_code    = out_fault_ff;
   assign rsp_chan.above_flag    = out_above_ff;
   assign rsp_chan.good_count    = out_good_ff;

endmodule

@@ tb/tb_ntc_lut_temperature.sv @@
module tb_ntc_lut_temperature;
   import ntc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_PCT    = 14;

   // thermistor curve, -5 C to 80 C in 5 C steps
   localparam int NTC_CURVE [18] = '{
      3338, 3155, 2959, 2738, 2509, 2275, 2048, 1828,
      1614, 1413, 1238, 1082,  937,  816,  708,  613,
       531,  461
   };

   typedef struct packed {
      logic [11:0] sample_a;
      logic [11:0] sample_b;
      logic [11:0] sample_c;
      logic [11:0] sample_d;
      logic        lost_a;
      logic        lost_b;
      logic        lost_c;
      logic        lost_d;
   } reading_word;

   typedef struct packed {
      logic signed [10:0] temp_tenths;
      logic               reading_valid;
      logic [2:0]         fault_code;
      logic               above_flag;
      logic [2:0]         good_count;
   } temp_report;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   ntc_req_if req_bus ();
   ntc_rsp_if rsp_bus ();

   ntc_lut_temperature DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // predictor state and register copies
   logic signed [10:0] held_tenths     = 11'sd250;
   logic signed [11:0] threshold_tenths = 12'sd500;
   logic [11:0]        open_limit      = 12'd10;
   logic [11:0]        short_limit     = 12'd4085;

   reading_word pending_readings [$];
   temp_report  predicted_reports [$];
   reading_word on_bus;
   logic        steady = 1'b0;
   int          mismatches = 0;
   int          cycle_count = 0;

   always #6 clock = ~clock;

   function automatic temp_report predict_temperature(reading_word w);
      logic [11:0] counts [4];
      logic [3:0]  lost;
      int          sum;
      int          good;
      int          avg;
      int          seg;
      int          lo;
      int          hi;
      int          frac;
      temp_report  r;
      counts = '{w.sample_a, w.sample_b, w.sample_c, w.sample_d};
      lost = {w.lost_a, w.lost_b, w.lost_c, w.lost_d};
      sum = 0;
      good = 0;
      for (int i = 0; i < 4; i++) begin
         if (!lost[3-i]) begin
            sum += counts[i];
            good++;
         end
      end
      r.reading_valid = 1'b0;
      if (good == 0) begin
         r.fault_code = FAULT_NONE_GOOD;
      end else begin
         avg = sum / good;
         if (avg < open_limit) begin
            r.fault_code = FAULT_OPEN;
         end else if (avg > short_limit) begin
            r.fault_code = FAULT_SHORT;
         end else begin
            r.fault_code = FAULT_OK;
            seg = 0;
            if (avg >= NTC_CURVE[0]) begin
               r.fault_code = FAULT_COLD;
            end else if (avg <= NTC_CURVE[17]) begin
               seg = 16;
               r.fault_code = FAULT_HOT;
            end else begin
               while (avg < NTC_CURVE[seg+1]) seg++;
            end
            lo = NTC_CURVE[seg];
            hi = NTC_CURVE[seg+1];
            frac = (lo > hi) ? ((lo - avg) * 100) / (lo - hi) : 0;
            if (frac < 0) frac = 0;
            if (frac > 100) frac = 100;
            held_tenths = 11'((seg * 5 - 5) * 10 + (50 * frac) / 100);
            r.reading_valid = 1'b1;
         end
      end
      r.temp_tenths = held_tenths;
      r.above_flag  = (held_tenths > threshold_tenths);
      r.good_count  = good[2:0];
      return r;
   endfunction

   function automatic reading_word reading_of(int a, int b, int c, int d, logic [3:0] lost);
      reading_word w;
      w.sample_a = a[11:0];
      w.sample_b = b[11:0];
      w.sample_c = c[11:0];
      w.sample_d = d[11:0];
      {w.lost_a, w.lost_b, w.lost_c, w.lost_d} = lost;
      return w;
   endfunction

   function automatic logic [11:0] near(int center, int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      else if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   function automatic reading_word random_reading();
      reading_word w;
      logic [3:0]  lost;
      int          pick;
      int          center;
      pick = $urandom_range(0, 99);
      for (int i = 0; i < 4; i++) lost[i] = ($urandom_range(0, 9) == 0);
      if (pick < 70) begin
         // mostly plausible readings: one level plus a little noise
         if (pick < 58) center = $urandom_range(300, 3600);
         else center = NTC_CURVE[$urandom_range(0, 17)];
         w = reading_of(near(center, pick < 58 ? 12 : 1), near(center, pick < 58 ? 12 : 1),
                        near(center, pick < 58 ? 12 : 1), near(center, pick < 58 ? 12 : 1),
                        lost);
      end else if (pick < 80) begin
         w = reading_of($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        4'($urandom_range(0, 15)));
      end else if (pick < 86) begin
         // all or all but one timed out
         lost = 4'b1111;
         if (pick < 83) lost[$urandom_range(0, 3)] = 1'b0;
         w = reading_of($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095), lost);
      end else if (pick < 93) begin
         center = $urandom_range(0, 30);
         w = reading_of(near(center, 5), near(center, 5), near(center, 5), near(center, 5), lost);
      end else begin
         center = $urandom_range(4075, 4095);
         w = reading_of(near(center, 10), near(center, 10), near(center, 10),
                        near(center, 10), lost);
      end
      return w;
   endfunction

   task automatic write_register(input logic [1:0] index, input int value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_THRESHOLD: threshold_tenths = value[11:0];
         REG_OPEN:      open_limit = value[11:0];
         REG_SHORT:     short_limit = value[11:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (pending_readings.size() != 0 || req_bus.valid || predicted_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid    <= 1'b0;
         req_bus.sample_a <= '0;
         req_bus.sample_b <= '0;
         req_bus.sample_c <= '0;
         req_bus.sample_d <= '0;
         req_bus.lost_a   <= 1'b0;
         req_bus.lost_b   <= 1'b0;
         req_bus.lost_c   <= 1'b0;
         req_bus.lost_d   <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            predicted_reports.push_back(predict_temperature(on_bus));
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_readings.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               on_bus = pending_readings.pop_front();
               req_bus.valid    <= 1'b1;
               req_bus.sample_a <= on_bus.sample_a;
               req_bus.sample_b <= on_bus.sample_b;
               req_bus.sample_c <= on_bus.sample_c;
               req_bus.sample_d <= on_bus.sample_d;
               req_bus.lost_a   <= on_bus.lost_a;
               req_bus.lost_b   <= on_bus.lost_b;
               req_bus.lost_c   <= on_bus.lost_c;
               req_bus.lost_d   <= on_bus.lost_d;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      temp_report want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_reports.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual temp %0d fault %0d",
                        $time, rsp_bus.temp_tenths, rsp_bus.fault_code);
               mismatches++;
            end else begin
               want = predicted_reports.pop_front();
               check_field("temp_tenths", want.temp_tenths, rsp_bus.temp_tenths);
               check_field("reading_valid", want.reading_valid, rsp_bus.reading_valid);
               check_field("fault_code", want.fault_code, rsp_bus.fault_code);
               check_field("above_flag", want.above_flag, rsp_bus.above_flag);
               check_field("good_count", want.good_count, rsp_bus.good_count);
            end
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_bus.valid    = 1'b0;
      req_bus.sample_a = '0;
      req_bus.sample_b = '0;
      req_bus.sample_c = '0;
      req_bus.sample_d = '0;
      req_bus.lost_a   = 1'b0;
      req_bus.lost_b   = 1'b0;
      req_bus.lost_c   = 1'b0;
      req_bus.lost_d   = 1'b0;
      rsp_bus.ready    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: limits, table ends, threshold edge, timeouts
      pending_readings.push_back(reading_of(0, 0, 0, 0, 4'b1111));
      pending_readings.push_back(reading_of(0, 0, 0, 0, 4'b0000));
      pending_readings.push_back(reading_of(4095, 4095, 4095, 4095, 4'b0000));
      pending_readings.push_back(reading_of(3338, 3338, 3338, 3338, 4'b0000));
      pending_readings.push_back(reading_of(4085, 4085, 4085, 4085, 4'b0000));
      pending_readings.push_back(reading_of(10, 10, 10, 10, 4'b0000));
      pending_readings.push_back(reading_of(461, 461, 461, 461, 4'b0000));
      pending_readings.push_back(reading_of(462, 462, 462, 462, 4'b0000));
      pending_readings.push_back(reading_of(3337, 3337, 3337, 3337, 4'b0000));
      pending_readings.push_back(reading_of(2048, 2048, 2048, 2048, 4'b0000));
      pending_readings.push_back(reading_of(1075, 1075, 1075, 1075, 4'b0000));
      pending_readings.push_back(reading_of(1082, 1082, 1082, 1082, 4'b0000));
      pending_readings.push_back(reading_of(1000, 1001, 1001, 1001, 4'b0000));
      pending_readings.push_back(reading_of(4095, 1500, 1500, 1500, 4'b1000));
      pending_readings.push_back(reading_of(12'hAAA, 12'h555, 12'hAAA, 12'h555, 4'b0101));
      pending_readings.push_back(reading_of(0, 0, 0, 1700, 4'b1110));
      pending_readings.push_back(reading_of(1000, 1000, 1001, 0, 4'b0001));
      pending_readings.push_back(reading_of(9, 9, 9, 9, 4'b0000));
      pending_readings.push_back(reading_of(4086, 4086, 4086, 4086, 4'b0000));
      pending_readings.push_back(reading_of(2500, 2500, 2500, 2500, 4'b1111));
      pending_readings.push_back(reading_of(4095, 0, 4095, 0, 4'b0000));
      drain();

      // widest limits, lowest threshold
      write_register(REG_THRESHOLD, -500);
      write_register(REG_OPEN, 0);
      write_register(REG_SHORT, 4095);
      pending_readings.push_back(reading_of(0, 0, 0, 0, 4'b0000));
      pending_readings.push_back(reading_of(4095, 4095, 4095, 4095, 4'b0000));
      repeat (200) pending_readings.push_back(random_reading());
      drain();

      // open limit above short limit: nothing passes, open wins
      write_register(REG_THRESHOLD, 1500);
      write_register(REG_OPEN, 4095);
      write_register(REG_SHORT, 0);
      repeat (60) pending_readings.push_back(random_reading());
      drain();

      // no idling on either side for this stretch
      write_register(REG_THRESHOLD, $urandom_range(0, 2000) - 500);
      write_register(REG_OPEN, $urandom_range(0, 400));
      write_register(REG_SHORT, $urandom_range(3400, 4095));
      steady = 1'b1;
      repeat (250) pending_readings.push_back(random_reading());
      drain();
      steady = 1'b0;

      write_register(REG_THRESHOLD, $urandom_range(0, 900) - 100);
      write_register(REG_OPEN, $urandom_range(0, 600));
      write_register(REG_SHORT, $urandom_range(3000, 4095));
      repeat (340) pending_readings.push_back(random_reading());
      drain();

      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
